[rtl/core/wtsm_pkg.sv]
// ----------------------------------------------------------------------------
// Whitespace-tolerant string match package
// Shared widths, character codes, register indexes and types.
// ----------------------------------------------------------------------------
package wtsm_pkg;

  localparam int MaxPattern = 16;
  localparam int RowW       = 24;
  localparam int ColW       = 16;
  localparam int CntW       = 24;
  localparam int PosW       = RowW + ColW;
  localparam int LenW       = 5;
  localparam int RegW       = 64;
  localparam int CfgIdxW    = 2;

  localparam logic [RowW-1:0] RowMax = {RowW{1'b1}};
  localparam logic [ColW-1:0] ColMax = {ColW{1'b1}};
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChNewline = 8'h0A;

  localparam logic KindMatch   = 1'b0;
  localparam logic KindSummary = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgPatternLow    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPatternHigh   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPatternLength = 2'd2;

  typedef struct packed {
    logic       step;
    logic       clear;
    logic [7:0] data_byte;
  } cell_ctrl_t;

  typedef struct packed {
    logic            seen;
    logic [PosW-1:0] pos;
  } link_t;

  typedef struct packed {
    logic            result_kind;
    logic [RowW-1:0] match_row;
    logic [ColW-1:0] match_column;
    logic [CntW-1:0] match_total;
    logic            last_result;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic is_space(input logic [7:0] ch);
    return (ch == ChSpace) || (ch == ChTab) || (ch == ChNewline);
  endfunction

endpackage

[rtl/core/wtsm_in_if.sv]
// ----------------------------------------------------------------------------
// Text byte channel
// Valid/ready channel carrying one text byte and its end-of-file flag.
// ----------------------------------------------------------------------------
interface wtsm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

[rtl/core/wtsm_out_if.sv]
// ----------------------------------------------------------------------------
// Match result channel
// Valid/ready channel carrying one match report or end-of-file summary.
// ----------------------------------------------------------------------------
interface wtsm_out_if;
  logic                      valid;
  logic                      ready;
  logic                      result_kind;
  logic [wtsm_pkg::RowW-1:0] match_row;
  logic [wtsm_pkg::ColW-1:0] match_column;
  logic [wtsm_pkg::CntW-1:0] match_total;
  logic                      last_result;

  modport source (output valid, output result_kind, output match_row, output match_column,
                  output match_total, output last_result, input ready);
  modport sink (input valid, input result_kind, input match_row, input match_column,
                input match_total, input last_result, output ready);
endinterface

[rtl/core/wtsm_cell.sv]
// ----------------------------------------------------------------------------
// Match cell
// Holds one partial-match bit and its start position, fed by its left neighbor.
// ----------------------------------------------------------------------------
module wtsm_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wtsm_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]           pat_char,
  input  logic                 active,
  input  logic                 is_top,
  input  wtsm_pkg::link_t      prev,
  output wtsm_pkg::link_t      cur,
  output logic                 hit
);

  logic                      seen_r;
  logic                      seen_nxt;
  logic [wtsm_pkg::PosW-1:0] pos_r;

  assign hit = active && prev.seen && (pat_char == ctrl.data_byte);

  always_comb begin
    seen_nxt = seen_r;
    if (ctrl.clear) begin
      seen_nxt = 1'b0;
    end else if (ctrl.step) begin
      seen_nxt = hit && !is_top;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step && hit) begin
      pos_r <= prev.pos;
    end
  end

  assign cur.seen = seen_r;
  assign cur.pos  = pos_r;

endmodule

[rtl/core/wtsm_out_queue.sv]
// ----------------------------------------------------------------------------
// Result queue
// Three-slot shifting queue taking up to two results per cycle, one out.
// ----------------------------------------------------------------------------
module wtsm_out_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  wtsm_pkg::push_t     push,
  output logic                room,
  wtsm_out_if.source          out_ch
);

  localparam int Depth = 3;

  wtsm_pkg::result_t slot_r   [Depth];
  wtsm_pkg::result_t slot_nxt [Depth];
  logic [1:0]        count_r;
  logic [1:0]        count_nxt;
  logic [1:0]        kept;
  logic              pop;

  assign pop  = out_ch.valid && out_ch.ready;
  assign kept = count_r - {1'b0, pop};
  assign room = (kept <= 2'd1);

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      if (pop && (i < Depth - 1)) begin
        slot_nxt[i] = slot_r[i + 1];
      end else begin
        slot_nxt[i] = slot_r[i];
      end
      if ((push.count != 2'd0) && (2'(i) == kept)) begin
        slot_nxt[i] = push.first;
      end
      if ((push.count == 2'd2) && (2'(i) == kept + 2'd1)) begin
        slot_nxt[i] = push.second;
      end
    end
    count_nxt = kept + push.count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Depth; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

  assign out_ch.valid        = (count_r != 2'd0);
  assign out_ch.result_kind  = slot_r[0].result_kind;
  assign out_ch.match_row    = slot_r[0].match_row;
  assign out_ch.match_column = slot_r[0].match_column;
  assign out_ch.match_total  = slot_r[0].match_total;
  assign out_ch.last_result  = slot_r[0].last_result;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3 || !room)
    else $error("queue full but still open for a transfer");
  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    push.count != 2'd0 |-> room)
    else $error("results pushed without room");
  a_last_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.result_kind == wtsm_pkg::KindSummary |-> out_ch.last_result)
    else $error("summary not marked as last result");
`endif

endmodule

[rtl/core/whitespace_tolerant_string_match.sv]
// ----------------------------------------------------------------------------
// Whitespace-tolerant string match
// Finds every occurrence of a configured pattern in a byte stream, allowing
// runs of spaces, tabs and newlines between pattern characters.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one text byte per transfer, with final_byte set on the
//   last byte of a file. out_ch carries match reports (row, column of the
//   first character and running count) and one summary per file.
//   The cfg_ port writes pattern_low, pattern_high and pattern_length; the user
//   must write it only while the block is idle. The block does not enforce this.
// Timing:
//   One byte is taken every cycle while the output queue has room. Each
//   non-whitespace byte steps a row of MAX_PATTERN cells once; results are
//   registered in a three-slot output queue before they appear on out_ch.
//   Up to two results per byte drain one per cycle while out_ch is ready.
// Reset and stall:
//   Reset clears the partial matches, sets row and column to 1, the count
//   to 0 and pattern_length to 1. When out_ch stalls, the queue holds the
//   results and in_ch.ready drops once fewer than two slots remain free.
// ----------------------------------------------------------------------------
module whitespace_tolerant_string_match #(
  parameter int MAX_PATTERN = wtsm_pkg::MaxPattern
) (
  input  logic                         clk,
  input  logic                         rst_n,
  wtsm_in_if.sink                      in_ch,
  wtsm_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [wtsm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [wtsm_pkg::RegW-1:0]    cfg_wdata
);

  localparam int IdxW     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LinkIdxW = $clog2(MAX_PATTERN + 1);

  logic [wtsm_pkg::RegW-1:0] pat_low_r;
  logic [wtsm_pkg::RegW-1:0] pat_high_r;
  logic [wtsm_pkg::LenW-1:0] pat_len_r;
  logic [wtsm_pkg::LenW-1:0] len_eff;
  logic [IdxW-1:0]           top_idx;
  logic [LinkIdxW-1:0]       top_link;

  logic [wtsm_pkg::RowW-1:0] row_r;
  logic [wtsm_pkg::RowW-1:0] row_nxt;
  logic [wtsm_pkg::ColW-1:0] col_r;
  logic [wtsm_pkg::ColW-1:0] col_nxt;
  logic [wtsm_pkg::CntW-1:0] cnt_r;
  logic [wtsm_pkg::CntW-1:0] cnt_nxt;
  logic [wtsm_pkg::CntW-1:0] cnt_inc;

  logic                      accept;
  logic                      room;
  logic                      match;
  logic [wtsm_pkg::PosW-1:0] match_pos;
  wtsm_pkg::cell_ctrl_t      ctrl;
  wtsm_pkg::link_t           link [MAX_PATTERN + 1];
  logic [MAX_PATTERN-1:0]    hit;
  wtsm_pkg::result_t         res_match;
  wtsm_pkg::result_t         res_summary;
  wtsm_pkg::push_t           push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= wtsm_pkg::LenW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        wtsm_pkg::CfgPatternLow:    pat_low_r  <= cfg_wdata;
        wtsm_pkg::CfgPatternHigh:   pat_high_r <= cfg_wdata;
        wtsm_pkg::CfgPatternLength: pat_len_r  <= cfg_wdata[wtsm_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len_eff = pat_len_r;
    if (pat_len_r == '0) begin
      len_eff = wtsm_pkg::LenW'(1);
    end else if (pat_len_r > wtsm_pkg::LenW'(MAX_PATTERN)) begin
      len_eff = wtsm_pkg::LenW'(MAX_PATTERN);
    end
  end

  assign top_idx  = IdxW'(len_eff - wtsm_pkg::LenW'(1));
  assign top_link = LinkIdxW'(top_idx);

  assign accept         = in_ch.valid && in_ch.ready;
  assign in_ch.ready    = room;
  assign ctrl.step      = accept && !wtsm_pkg::is_space(in_ch.data_byte);
  assign ctrl.clear     = accept && in_ch.final_byte;
  assign ctrl.data_byte = in_ch.data_byte;

  assign link[0].seen = 1'b1;
  assign link[0].pos  = {row_r, col_r};

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [7:0] pat_char;
    if (k < 8) begin : g_low
      assign pat_char = pat_low_r[8*k +: 8];
    end else begin : g_high
      assign pat_char = pat_high_r[8*(k-8) +: 8];
    end

    wtsm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .pat_char (pat_char),
      .active   (wtsm_pkg::LenW'(k) < len_eff),
      .is_top   (IdxW'(k) == top_idx),
      .prev     (link[k]),
      .cur      (link[k+1]),
      .hit      (hit[k])
    );
  end

  assign match     = ctrl.step && hit[top_idx];
  assign match_pos = link[top_link].pos;
  assign cnt_inc   = (match && cnt_r != wtsm_pkg::CntMax) ? cnt_r + 1'b1 : cnt_r;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = cnt_inc;
      if (in_ch.data_byte == wtsm_pkg::ChNewline) begin
        if (row_r != wtsm_pkg::RowMax) begin
          row_nxt = row_r + 1'b1;
        end
        col_nxt = wtsm_pkg::ColW'(1);
      end else if (col_r != wtsm_pkg::ColMax) begin
        col_nxt = col_r + 1'b1;
      end
      if (in_ch.final_byte) begin
        row_nxt = wtsm_pkg::RowW'(1);
        col_nxt = wtsm_pkg::ColW'(1);
        cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= wtsm_pkg::RowW'(1);
      col_r <= wtsm_pkg::ColW'(1);
      cnt_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign res_match.result_kind  = wtsm_pkg::KindMatch;
  assign res_match.match_row    = match_pos[wtsm_pkg::PosW-1:wtsm_pkg::ColW];
  assign res_match.match_column = match_pos[wtsm_pkg::ColW-1:0];
  assign res_match.match_total  = cnt_inc;
  assign res_match.last_result  = !in_ch.final_byte;

  assign res_summary.result_kind  = wtsm_pkg::KindSummary;
  assign res_summary.match_row    = '0;
  assign res_summary.match_column = '0;
  assign res_summary.match_total  = cnt_inc;
  assign res_summary.last_result  = 1'b1;

  assign push.count  = accept ? ({1'b0, match} + {1'b0, in_ch.final_byte}) : 2'd0;
  assign push.first  = match ? res_match : res_summary;
  assign push.second = res_summary;

  wtsm_out_queue u_out_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.final_byte |=> row_r == wtsm_pkg::RowW'(1)
      && col_r == wtsm_pkg::ColW'(1) && cnt_r == '0)
    else $error("counters not cleared after the final byte");
  a_final_reports: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.final_byte |=> out_ch.valid)
    else $error("no summary queued after the final byte");
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && in_ch.final_byte) |=> cnt_r >= $past(cnt_r))
    else $error("match count decreased within a file");
  a_column_steps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_ch.final_byte && in_ch.data_byte != wtsm_pkg::ChNewline
      && col_r != wtsm_pkg::ColMax |=> col_r == $past(col_r) + 1'b1)
    else $error("column did not advance");
`endif

endmodule
